// ===== sv/trrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrq_pkg
// Shared types, widths and helpers for the tagged read retry queue.
// ----------------------------------------------------------------------------
package trrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_MODULUS = 127;
  localparam int KEY_OFFSET  = 32;

  localparam int KEY_W       = 8;
  localparam int NEXT_KEY_W  = 7;
  localparam int TAG_LOW_W   = 64;
  localparam int TAG_HIGH_W  = 16;
  localparam int TIME_W      = 31;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = 10;
  localparam int DIGITS_W    = DIGIT_W * DIGITS;
  localparam int COUNT_OUT_W = 7;

  // Binary-to-BCD converter: two bits shifted in per cycle.
  localparam int BCD_BITS_PER_STEP = 2;
  localparam int BCD_BIN_W  =
    ((TIME_W + BCD_BITS_PER_STEP - 1) / BCD_BITS_PER_STEP) * BCD_BITS_PER_STEP;
  localparam int BCD_STEPS  = BCD_BIN_W / BCD_BITS_PER_STEP;
  localparam int STEP_CNT_W = (BCD_STEPS > 1) ? $clog2(BCD_STEPS) : 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } trrq_op_t;

  typedef struct packed {
    logic [TAG_LOW_W-1:0]  tag_low;
    logic [TAG_HIGH_W-1:0] tag_high;
    logic [DIGITS_W-1:0]   time_digits;
    logic [KEY_W-1:0]      key;
  } trrq_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_HEAD_RD,
    ST_OUT
  } trrq_state_t;

  // One double-dabble step: adjust every digit of five or more by three,
  // then shift the next binary bit in at the bottom.
  function automatic logic [DIGITS_W-1:0] dabble_bit(input logic [DIGITS_W-1:0] bcd,
                                                     input logic              b);
    logic [DIGITS_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (adj[DIGIT_W*d +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[DIGIT_W*d +: DIGIT_W] = adj[DIGIT_W*d +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    return {adj[DIGITS_W-2:0], b};
  endfunction

endpackage

// ===== sv/trrq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/trrq_bcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrq_bcd
// Iterative binary to ten-digit BCD converter (double dabble, two bits a cycle).
// ----------------------------------------------------------------------------
module trrq_bcd import trrq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TIME_W-1:0]   value,
  output logic                done,
  output logic [DIGITS_W-1:0] digits
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;
  logic [BCD_BIN_W-1:0]  bin_r, bin_nxt;
  logic [DIGITS_W-1:0]   bcd_r, bcd_nxt;
  logic [DIGITS_W-1:0]   acc;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    acc      = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      bin_nxt  = BCD_BIN_W'(value);
      bcd_nxt  = '0;
    end else if (busy_r) begin
      for (int k = 0; k < BCD_BITS_PER_STEP; k++) begin
        acc = dabble_bit(acc, bin_r[BCD_BIN_W-1-k]);
      end
      bcd_nxt  = acc;
      bin_nxt  = bin_r << BCD_BITS_PER_STEP;
      step_nxt = step_r + STEP_CNT_W'(1);
      if (step_r == STEP_CNT_W'(BCD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

// ===== sv/tagged_read_retry_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_read_retry_queue
// Bounded, ordered queue of tag reads awaiting acknowledgement.
// ----------------------------------------------------------------------------
// An insert word stores its 10-byte tag, its timestamp as ten BCD digits and
// a sequence key (a counter that runs 0..126 and wraps, plus 32) at the tail,
// if the queue has room; a full queue drops it with accepted low. A remove
// word deletes the oldest entry whose key matches and moves later entries
// down one place. Every word gives exactly one result with the entry count
// and the head entry (all zero when empty). One word is worked at a time:
// a stored insert waits on the 16-step binary-to-BCD converter; a remove
// reads and checks each entry scanned and reads and writes each entry moved,
// paced by the single read port of the entry RAM and its registered read.
// An insert dropped on a full queue, or a remove on an empty one, goes
// straight to the head read. A new word is taken as soon as the sequencer
// is idle, even while the last result still sits in the output register.
// ----------------------------------------------------------------------------
module tagged_read_retry_queue import trrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic [TAG_LOW_W-1:0]   in_tag_low,
  input  logic [TAG_HIGH_W-1:0]  in_tag_high,
  input  logic [TIME_W-1:0]      in_timestamp,
  input  logic [KEY_W-1:0]       in_remove_key,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_accepted,
  output logic                   out_removed,
  output logic [KEY_W-1:0]       out_assigned_key,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic                   out_head_valid,
  output logic [TAG_LOW_W-1:0]   out_head_tag_low,
  output logic [TAG_HIGH_W-1:0]  out_head_tag_high,
  output logic [DIGITS_W-1:0]    out_head_time_digits,
  output logic [KEY_W-1:0]       out_head_key
);

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(trrq_entry_t);

  // sequencer and queue bookkeeping
  trrq_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [NEXT_KEY_W-1:0]  next_key_r, next_key_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       idx_inc, idx_dec;

  // latched word under work
  trrq_op_t               op_r, op_nxt;
  logic [TAG_LOW_W-1:0]   tag_low_r, tag_low_nxt;
  logic [TAG_HIGH_W-1:0]  tag_high_r, tag_high_nxt;
  logic [KEY_W-1:0]       rkey_r, rkey_nxt;
  logic                   accepted_r, accepted_nxt;
  logic                   removed_r, removed_nxt;
  logic [KEY_W-1:0]       akey_r, akey_nxt;
  logic [KEY_W-1:0]       new_key;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_accepted_r, out_accepted_nxt;
  logic                   out_removed_r, out_removed_nxt;
  logic [KEY_W-1:0]       out_akey_r, out_akey_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_hvalid_r, out_hvalid_nxt;
  trrq_entry_t            out_head_r, out_head_nxt;

  // entry RAM
  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  trrq_entry_t            ram_wdata, ram_rdata;

  // converter
  logic                   bcd_start, bcd_done;
  logic [DIGITS_W-1:0]    bcd_digits;

  trrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  trrq_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .value  (in_timestamp),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  // Take a word only when the sequencer is idle.
  assign in_stall = (state_r != ST_IDLE);

  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign new_key = KEY_W'(next_key_r) + KEY_W'(KEY_OFFSET);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    next_key_nxt     = next_key_r;
    idx_nxt          = idx_r;
    op_nxt           = op_r;
    tag_low_nxt      = tag_low_r;
    tag_high_nxt     = tag_high_r;
    rkey_nxt         = rkey_r;
    accepted_nxt     = accepted_r;
    removed_nxt      = removed_r;
    akey_nxt         = akey_r;
    // drop the held result once it is taken
    out_valid_nxt    = out_valid_r & out_stall;
    out_accepted_nxt = out_accepted_r;
    out_removed_nxt  = out_removed_r;
    out_akey_nxt     = out_akey_r;
    out_count_nxt    = out_count_r;
    out_hvalid_nxt   = out_hvalid_r;
    out_head_nxt     = out_head_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = idx_r[IDX_W-1:0];
    ram_raddr        = idx_r[IDX_W-1:0];
    ram_wdata        = ram_rdata;
    bcd_start        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = trrq_op_t'(in_operation);
          tag_low_nxt  = in_tag_low;
          tag_high_nxt = in_tag_high;
          rkey_nxt     = in_remove_key;
          accepted_nxt = 1'b0;
          removed_nxt  = 1'b0;
          akey_nxt     = '0;
          idx_nxt      = '0;
          if (trrq_op_t'(in_operation) == OP_INSERT) begin
            if (count_r < CNT_W'(QUEUE_DEPTH)) begin
              bcd_start = 1'b1;
              state_nxt = ST_CONV;
            end else begin
              // full: drop the insert, report only
              state_nxt = ST_HEAD_RD;
            end
          end else if (count_r != '0) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_HEAD_RD;
          end
        end
      end

      ST_CONV: begin
        if (bcd_done) begin
          state_nxt = ST_WRITE;
        end
      end

      ST_WRITE: begin
        // append at the tail and advance the key counter
        ram_we                = 1'b1;
        ram_waddr             = count_r[IDX_W-1:0];
        ram_wdata.tag_low     = tag_low_r;
        ram_wdata.tag_high    = tag_high_r;
        ram_wdata.time_digits = bcd_digits;
        ram_wdata.key         = new_key;
        count_nxt             = count_r + CNT_W'(1);
        next_key_nxt          = (next_key_r == NEXT_KEY_W'(KEY_MODULUS - 1)) ?
                                '0 : next_key_r + NEXT_KEY_W'(1);
        accepted_nxt          = 1'b1;
        akey_nxt              = new_key;
        state_nxt             = ST_HEAD_RD;
      end

      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        idx_nxt = idx_inc;
        if (ram_rdata.key == rkey_r) begin
          removed_nxt = 1'b1;
          if (idx_inc < count_r) begin
            state_nxt = ST_SHIFT_RD;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_HEAD_RD;
          end
        end else if (idx_inc < count_r) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_HEAD_RD;
        end
      end

      ST_SHIFT_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        // move the entry just read down one place
        ram_we    = 1'b1;
        ram_waddr = idx_dec[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        if (idx_inc < count_r) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_HEAD_RD;
        end
      end

      ST_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = accepted_r;
          out_removed_nxt  = removed_r;
          out_akey_nxt     = akey_r;
          out_count_nxt    = COUNT_OUT_W'(count_r);
          out_hvalid_nxt   = (count_r != '0);
          out_head_nxt     = (count_r != '0) ? ram_rdata : '0;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_key_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_key_r  <= next_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    op_r           <= op_nxt;
    tag_low_r      <= tag_low_nxt;
    tag_high_r     <= tag_high_nxt;
    rkey_r         <= rkey_nxt;
    accepted_r     <= accepted_nxt;
    removed_r      <= removed_nxt;
    akey_r         <= akey_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_removed_r  <= out_removed_nxt;
    out_akey_r     <= out_akey_nxt;
    out_count_r    <= out_count_nxt;
    out_hvalid_r   <= out_hvalid_nxt;
    out_head_r     <= out_head_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_accepted_r;
  assign out_removed          = out_removed_r;
  assign out_assigned_key     = out_akey_r;
  assign out_entry_count      = out_count_r;
  assign out_head_valid       = out_hvalid_r;
  assign out_head_tag_low     = out_head_r.tag_low;
  assign out_head_tag_high    = out_head_r.tag_high;
  assign out_head_time_digits = out_head_r.time_digits;
  assign out_head_key         = out_head_r.key;

endmodule
